// ----- sv/multi_list_node_pool_macros.svh -----
// Assertion macros shared by the node pool RTL.
// They expect signals named clk and rst in the scope of use.
`ifndef MULTI_LIST_NODE_POOL_MACROS_SVH
`define MULTI_LIST_NODE_POOL_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define MLNP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mlnp check failed");

// The consequent holds in the cycle after the antecedent.
`define MLNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlnp check failed");

`endif

// ----- sv/mlnp_pkg.sv -----
// Package for the node pool: request and response types and codes.
// Used by multi_list_node_pool; depends on nothing.
package mlnp_pkg;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_BAD_LIST  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NO_IDS    = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         list_number;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] list_id;
    logic [6:0] list_length;
    logic [6:0] total_used;
  } rsp_t;

endpackage

// ----- sv/mlnp_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the node and list tables of the node pool; no dependencies.
module mlnp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/multi_list_node_pool.sv -----
// Top level of the node pool shared by several doubly linked lists.
// Depends on mlnp_pkg, mlnp_ram and multi_list_node_pool_macros.svh.
//
// channel | payload | handshake
// req     | req_t   | req_valid / req_ready
// rsp     | rsp_t   | rsp_valid / rsp_ready
//
// One request is worked on at a time. The time a create takes from one transfer to the
// next is set by the scan of the in-use bits for the lowest free node. An append adds
// a walk along the links to the tail, and a delete a search of its nodes, each step a
// read of the node memories.
// Reset clears the node count and in-use bits and sets the list id counter to one at once; there is no clearing pass.
// A response waiting on rsp_ready holds the next request in its last state.
module multi_list_node_pool
  import mlnp_pkg::*;
#(
  parameter int NODES = 64,
  parameter int LISTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_ready,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready
);

  `include "multi_list_node_pool_macros.svh"

  localparam int NW   = $clog2(NODES);
  localparam int CW   = $clog2(NODES + 1);
  localparam int LW   = $clog2(LISTS);
  localparam int NIDW = $clog2(LISTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LIST, S_FREE, S_WALK, S_WWAIT, S_DREAD, S_DCHK, S_DONE
  } state_t;

  state_t          state;
  req_t            r_req;
  logic [NW-1:0]   hd;
  logic [CW-1:0]   len;
  logic [NW-1:0]   cur;
  logic [CW-1:0]   pos;
  logic [NW-1:0]   f;
  logic [NW-1:0]   scan;
  logic [CW-1:0]   used;
  logic [NIDW-1:0] nid;
  logic [NODES-1:0] in_use;
  rsp_t            res;

  logic            val_we, nxt_we, prv_we, head_we, len_we;
  logic [NW-1:0]   val_wa, nxt_wa, prv_wa;
  logic [NW-1:0]   nxt_wd, prv_wd, head_wd;
  logic [LW-1:0]   head_wa, len_wa, list_ra;
  logic [CW-1:0]   len_wd;
  logic [31:0]     rd_value;
  logic [NW-1:0]   rd_next, rd_prev, rd_head;
  logic [CW-1:0]   rd_len;

  logic            free_hit, walk_end, del_hit, is_head, is_tail, ln_ok;
  logic [LW-1:0]   ln_idx, nid_idx;

  assign req_ready = (state == S_IDLE);
  assign ln_idx    = LW'(r_req.list_number);
  assign nid_idx   = LW'(nid);
  assign list_ra   = LW'(req.list_number);
  assign ln_ok     = (r_req.list_number != 6'd0) && (32'(r_req.list_number) < 32'(nid));
  assign free_hit  = (state == S_FREE) && !in_use[scan];
  assign walk_end  = (state == S_WALK) && (pos == len);
  assign del_hit   = (state == S_DCHK) && (rd_value == 32'(r_req.key));
  assign is_head   = (pos == '0);
  assign is_tail   = ((pos + CW'(1)) == len);

  always_comb begin
    val_we  = free_hit;
    val_wa  = scan;
    head_we = 1'b0;
    head_wa = ln_idx;
    head_wd = scan;
    len_we  = 1'b0;
    len_wa  = ln_idx;
    len_wd  = CW'(1);
    nxt_we  = 1'b0;
    nxt_wa  = cur;
    nxt_wd  = f;
    prv_we  = 1'b0;
    prv_wa  = f;
    prv_wd  = cur;
    if (free_hit && (r_req.req_type == REQ_CREATE)) begin
      head_we = 1'b1;
      head_wa = nid_idx;
      len_we  = 1'b1;
      len_wa  = nid_idx;
    end
    if (free_hit && (r_req.req_type == REQ_APPEND) && (len == '0)) begin
      head_we = 1'b1;
      len_we  = 1'b1;
    end
    if (walk_end) begin
      len_we = 1'b1;
      len_wd = len + CW'(1);
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end
    if (del_hit) begin
      len_we = 1'b1;
      len_wd = len - CW'(1);
      if (is_head && !is_tail) begin
        head_we = 1'b1;
        head_wd = rd_next;
      end
      if (!is_head && !is_tail) begin
        nxt_we = 1'b1;
        nxt_wa = rd_prev;
        nxt_wd = rd_next;
        prv_we = 1'b1;
        prv_wa = rd_next;
        prv_wd = rd_prev;
      end
    end
  end

  mlnp_ram #(.W(32), .DEPTH(NODES)) u_value (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(32'(r_req.key)),
    .raddr(cur), .rdata(rd_value)
  );
  mlnp_ram #(.W(NW), .DEPTH(NODES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .raddr(cur), .rdata(rd_next)
  );
  mlnp_ram #(.W(NW), .DEPTH(NODES)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .raddr(cur), .rdata(rd_prev)
  );
  mlnp_ram #(.W(NW), .DEPTH(LISTS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(list_ra), .rdata(rd_head)
  );
  mlnp_ram #(.W(CW), .DEPTH(LISTS)) u_len (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
    .raddr(list_ra), .rdata(rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      nid       <= NIDW'(1);
      in_use    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            r_req <= req;
            state <= S_LIST;
          end
        end
        S_LIST: begin
          hd   <= rd_head;
          len  <= rd_len;
          scan <= '0;
          cur  <= rd_head;
          pos  <= '0;
          if (r_req.req_type == REQ_CREATE) begin
            res.list_id     <= 6'd0;
            res.list_length <= 7'd0;
            if (32'(nid) >= LISTS) begin
              res.status <= ST_NO_IDS;
              state      <= S_DONE;
            end else begin
              res.status <= ST_OK;
              state      <= S_FREE;
            end
          end else if (!ln_ok) begin
            res.list_id     <= r_req.list_number;
            res.list_length <= 7'd0;
            res.status <= (r_req.req_type == REQ_QUERY) ? ST_OK : ST_BAD_LIST;
            state      <= S_DONE;
          end else begin
            res.list_id     <= r_req.list_number;
            res.list_length <= 7'(rd_len);
            if (r_req.req_type == REQ_APPEND) begin
              res.status <= ST_OK;
              state      <= S_FREE;
            end else if ((r_req.req_type == REQ_DELETE) && (rd_len == '0)) begin
              res.status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (r_req.req_type == REQ_DELETE) begin
              res.status <= ST_OK;
              state      <= S_DREAD;
            end else begin
              res.status <= ST_OK;
              state      <= S_DONE;
            end
          end
        end
        S_FREE: begin
          if (free_hit) begin
            in_use[scan] <= 1'b1;
            f <= scan;
            if (r_req.req_type == REQ_CREATE) begin
              used            <= used + CW'(1);
              nid             <= nid + NIDW'(1);
              res.list_id     <= 6'(nid);
              res.list_length <= 7'd1;
              state           <= S_DONE;
            end else if (len == '0) begin
              used            <= used + CW'(1);
              res.list_length <= 7'd1;
              state           <= S_DONE;
            end else begin
              cur   <= hd;
              pos   <= CW'(1);
              state <= S_WALK;
            end
          end else if (scan == NW'(NODES - 1)) begin
            res.status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            scan <= scan + NW'(1);
          end
        end
        S_WALK: begin
          if (walk_end) begin
            used            <= used + CW'(1);
            res.list_length <= 7'(len + CW'(1));
            state           <= S_DONE;
          end else begin
            state <= S_WWAIT;
          end
        end
        S_WWAIT: begin
          cur   <= rd_next;
          pos   <= pos + CW'(1);
          state <= S_WALK;
        end
        S_DREAD: begin
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (del_hit) begin
            in_use[cur] <= 1'b0;
            if (used != '0) begin
              used <= used - CW'(1);
            end
            res.list_length <= 7'(len - CW'(1));
            state           <= S_DONE;
          end else if (is_tail) begin
            res.status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            cur   <= rd_next;
            pos   <= pos + CW'(1);
            state <= S_DREAD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status      <= res.status;
            rsp.list_id     <= res.list_id;
            rsp.list_length <= res.list_length;
            rsp.total_used  <= 7'(used);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MLNP_ASSERT_ALWAYS(a_used_matches_bits, (state != S_IDLE) || ($countones(in_use) == 32'(used)))
  `MLNP_ASSERT_ALWAYS(a_nid_range, (nid != '0) && (32'(nid) <= LISTS))
  `MLNP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  `MLNP_ASSERT_ALWAYS(a_walk_bound, (state != S_WALK) || (pos <= len))

endmodule

// ----- test/multi_list_node_pool_checker.sv -----
// Checker for the node pool: watches both channels, predicts each response
// from the accepted requests and compares each whole response against it.
// Depends on mlnp_pkg only.
`timescale 1ns / 1ps

module multi_list_node_pool_checker
  import mlnp_pkg::*;
#(
  parameter int NODES = 64,
  parameter int LISTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  input  logic req_ready,
  input  rsp_t rsp,
  input  logic rsp_valid,
  input  logic rsp_ready,
  output int   errors,
  output int   pending
);

  logic [31:0] key_of   [NODES];
  int          next_of  [NODES];
  int          prev_of  [NODES];
  bit          taken    [NODES];
  int          head_of  [LISTS];
  int          len_of   [LISTS];
  int          next_id;
  int          nodes_used;
  rsp_t        expected_rsps[$];

  function automatic int lowest_free();
    for (int i = 0; i < NODES; i++) begin
      if (!taken[i]) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t make_rsp(logic [2:0] st, int id, int len);
    rsp_t r;
    r.status = st;
    r.list_id = id[5:0];
    r.list_length = len[6:0];
    r.total_used = nodes_used[6:0];
    return r;
  endfunction

  function automatic rsp_t pool_update(req_t q);
    int ln;
    int f;
    int len;
    int cur;
    int pos;
    bit found;
    ln = int'(q.list_number);
    if (q.req_type == REQ_CREATE) begin
      if (next_id >= LISTS) return make_rsp(ST_NO_IDS, 0, 0);
      f = lowest_free();
      if (f < 0) return make_rsp(ST_NO_FREE, 0, 0);
      key_of[f] = q.key;
      taken[f] = 1'b1;
      head_of[next_id] = f;
      len_of[next_id] = 1;
      next_id++;
      nodes_used++;
      return make_rsp(ST_OK, next_id - 1, 1);
    end
    if (!(ln >= 1 && ln < next_id)) begin
      return make_rsp(q.req_type == REQ_QUERY ? ST_OK : ST_BAD_LIST, ln, 0);
    end
    len = len_of[ln];
    if (q.req_type == REQ_QUERY) return make_rsp(ST_OK, ln, len);
    if (q.req_type == REQ_APPEND) begin
      f = lowest_free();
      if (f < 0) return make_rsp(ST_NO_FREE, ln, len);
      key_of[f] = q.key;
      taken[f] = 1'b1;
      if (len == 0) begin
        head_of[ln] = f;
      end else begin
        cur = head_of[ln];
        for (int k = 1; k < len; k++) cur = next_of[cur];
        next_of[cur] = f;
        prev_of[f] = cur;
      end
      len_of[ln] = len + 1;
      nodes_used++;
      return make_rsp(ST_OK, ln, len + 1);
    end
    cur = head_of[ln];
    found = 1'b0;
    pos = 0;
    for (pos = 0; pos < len; pos++) begin
      if (key_of[cur] == q.key) begin
        found = 1'b1;
        break;
      end
      if (pos + 1 < len) cur = next_of[cur];
    end
    if (!found) return make_rsp(ST_NOT_FOUND, ln, len);
    if (pos == 0 && len > 1) begin
      head_of[ln] = next_of[cur];
    end else if (pos != 0 && pos + 1 != len) begin
      next_of[prev_of[cur]] = next_of[cur];
      prev_of[next_of[cur]] = prev_of[cur];
    end
    taken[cur] = 1'b0;
    len_of[ln] = len - 1;
    if (nodes_used > 0) nodes_used--;
    return make_rsp(ST_OK, ln, len - 1);
  endfunction

  initial begin
    errors = 0;
    next_id = 1;
    nodes_used = 0;
    for (int i = 0; i < NODES; i++) begin
      key_of[i] = '0;
      next_of[i] = 0;
      prev_of[i] = 0;
      taken[i] = 1'b0;
    end
    for (int i = 0; i < LISTS; i++) begin
      head_of[i] = 0;
      len_of[i] = 0;
    end
  end

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("Unexpected response transfer: %p", rsp);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp !== want) begin
            errors <= errors + 1;
            if (errors < 10) $display("Mismatch: expected %p, got %p", want, rsp);
          end
        end
      end
      if (req_valid && req_ready) expected_rsps.push_back(pool_update(req));
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the node pool testbench: clock, reset, request stimulus and
// response back-pressure. Depends on mlnp_pkg, multi_list_node_pool and
// multi_list_node_pool_checker.
`timescale 1ns / 1ps

module testbench;
  import mlnp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  int   errors;
  int   pending;
  bit   quiet = 1'b0;
  bit   hold_request = 1'b0;
  int   stall_cycles = 0;

  logic [31:0] list_keys[64][$];
  int          lists_made = 0;
  int          keys_held = 0;

  always #4 clk = ~clk;

  multi_list_node_pool uut (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_ready(req_ready),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
  );

  multi_list_node_pool_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_ready(req_ready),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .errors(errors), .pending(pending)
  );

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request && stall_cycles == 0) stall_cycles <= 300;
    else if (stall_cycles > 0) stall_cycles <= stall_cycles - 1;
    if (stall_cycles > 1) rsp_ready <= 1'b0;
    else rsp_ready <= quiet || ($urandom_range(99) >= 15);
  end

  int idle_count = 0;
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("FAIL multi_list_node_pool");
      $finish;
    end
  end

  // Keeps the list contents so that deletes can aim at keys that exist.
  task automatic track(req_t q);
    int ln;
    ln = int'(q.list_number);
    if (q.req_type == REQ_CREATE) begin
      if (lists_made < 63 && keys_held < 64) begin
        lists_made++;
        list_keys[lists_made].push_back(q.key);
        keys_held++;
      end
    end else if (ln >= 1 && ln <= lists_made) begin
      if (q.req_type == REQ_APPEND && keys_held < 64) begin
        list_keys[ln].push_back(q.key);
        keys_held++;
      end else if (q.req_type == REQ_DELETE) begin
        for (int i = 0; i < list_keys[ln].size(); i++) begin
          if (list_keys[ln][i] == q.key) begin
            list_keys[ln].delete(i);
            keys_held--;
            break;
          end
        end
      end
    end
  endtask

  task automatic send(logic [1:0] kind, logic [5:0] ln, logic [31:0] k);
    req_t q;
    q.req_type = kind;
    q.list_number = ln;
    q.key = k;
    track(q);
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (!quiet && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_key();
    return ($urandom_range(1) == 0) ? 32'($urandom_range(7)) : $urandom;
  endfunction

  function automatic logic [5:0] random_list();
    if (lists_made == 0 || $urandom_range(9) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(1, lists_made));
  endfunction

  initial begin
    logic [5:0] ln;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(REQ_QUERY, 6'd0, 32'h0);
    send(REQ_APPEND, 6'd1, 32'h1);
    send(REQ_DELETE, 6'd63, 32'h1);
    send(REQ_CREATE, 6'd63, 32'h8000_0000);
    send(REQ_APPEND, 6'd1, 32'h7fff_ffff);
    send(REQ_APPEND, 6'd1, 32'hffff_ffff);
    send(REQ_APPEND, 6'd1, 32'h0);
    send(REQ_QUERY, 6'd1, 32'h0);
    send(REQ_DELETE, 6'd1, 32'h1234_5678);
    send(REQ_DELETE, 6'd1, 32'hffff_ffff);
    send(REQ_DELETE, 6'd1, 32'h8000_0000);
    send(REQ_DELETE, 6'd1, 32'h0);
    send(REQ_DELETE, 6'd1, 32'h7fff_ffff);
    send(REQ_QUERY, 6'd1, 32'h0);
    send(REQ_DELETE, 6'd1, 32'h0);
    send(REQ_APPEND, 6'd1, 32'h5);
    send(REQ_CREATE, 6'd0, 32'h5);
    send(REQ_APPEND, 6'd2, 32'h5);
    send(REQ_DELETE, 6'd2, 32'h5);
    send(REQ_APPEND, 6'd3, 32'h5);
    send(REQ_QUERY, 6'd63, 32'hffff_ffff);

    for (int n = 0; n < 450; n++) begin
      quiet = (n >= 200 && n < 300);
      if (n == 120) hold_request = 1'b1;
      if (n == 121) hold_request = 1'b0;
      pick = $urandom_range(99);
      ln = random_list();
      if (pick < 15) begin
        send(REQ_CREATE, 6'($urandom_range(63)), random_key());
      end else if (pick < 22) begin
        send(REQ_QUERY, ln, random_key());
      end else if ((pick < 70) == ((n / 80) % 2 == 0)) begin
        send(REQ_APPEND, ln, random_key());
      end else if (list_keys[ln].size() > 0 && $urandom_range(9) != 0) begin
        send(REQ_DELETE, ln, list_keys[ln][$urandom_range(list_keys[ln].size() - 1)]);
      end else begin
        send(REQ_DELETE, ln, random_key());
      end
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS multi_list_node_pool");
    end else begin
      $display("FAIL multi_list_node_pool");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/mlnp_pkg.sv
sv/mlnp_ram.sv
sv/multi_list_node_pool.sv
test/multi_list_node_pool_checker.sv
test/testbench.sv
